// File: sv/ptc_pkg.sv
// shared types and constants for the pressure/temperature compensation core
// no dependencies
package ptc_pkg;
    localparam int unsigned NumRegs = 7;
    localparam logic [2:0] RegT1   = 3'd0;
    localparam logic [2:0] RegT2T3 = 3'd1;
    localparam logic [2:0] RegP1   = 3'd2;
    localparam logic [2:0] RegP2P3 = 3'd3;
    localparam logic [2:0] RegP4P5 = 3'd4;
    localparam logic [2:0] RegP6P7 = 3'd5;
    localparam logic [2:0] RegP8P9 = 3'd6;

    localparam logic [31:0] POffset  = 32'd64000;
    localparam logic [31:0] PBase    = 32'd1048576;
    localparam logic [31:0] PScale   = 32'd3125;
    localparam logic [31:0] PSignBit = 32'h8000_0000;
    localparam logic [31:0] DivBias  = 32'd32768;
    localparam logic [31:0] TRound   = 32'd128;

    // control handed from the front pipeline to the divider
    typedef struct packed {
        logic        vld;
        logic [31:0] num;
        logic [31:0] den;
        logic        dbl_after;
    } t_div_req;

    function automatic logic [31:0] sar(input logic [31:0] x, input int unsigned s);
        sar = 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage

// File: sv/pressure_temperature_compensation_core.sv
// pressure/temperature compensation core, 32-bit integer scheme
// pipeline: 8 front stages, 32 divider stages, 2 back stages and an output register
// throughput: one reading pair per cycle; the whole pipeline holds on output stall
// the 32-stage divider is part of the stall path and advances only when the output can move
// reset (synchronous, active low) clears valid bits and calibration registers
// depends on ptc_pkg and ptc_div
module pressure_temperature_compensation_core
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // temperature_centi[31:0], pressure_pa[63:32]
    output logic        m_axis_tuser   // divisor_zero
);
    logic [31:0] r_reg [NumRegs];
    logic en;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) r_reg[i] <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == RegT1 || i_cfg_index == RegP1)
                r_reg[i_cfg_index] <= {16'd0, i_cfg_data[15:0]};
            else if (i_cfg_index <= RegP8P9)
                r_reg[i_cfg_index] <= i_cfg_data;
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_reg[RegT1];
    assign t2 = sx16(r_reg[RegT2T3][15:0]);
    assign t3 = sx16(r_reg[RegT2T3][31:16]);
    assign p1 = r_reg[RegP1];
    assign p2 = sx16(r_reg[RegP2P3][15:0]);
    assign p3 = sx16(r_reg[RegP2P3][31:16]);
    assign p4 = sx16(r_reg[RegP4P5][15:0]);
    assign p5 = sx16(r_reg[RegP4P5][31:16]);
    assign p6 = sx16(r_reg[RegP6P7][15:0]);
    assign p7 = sx16(r_reg[RegP6P7][31:16]);
    assign p8 = sx16(r_reg[RegP8P9][15:0]);
    assign p9 = sx16(r_reg[RegP8P9][31:16]);

    // whole pipeline advances unless the output register is full and stalled
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: temperature products
    logic        r1_v;
    logic [31:0] r1_a, r1_dd;
    logic [19:0] r1_p;
    logic [31:0] n1_x, n1_d;
    assign n1_x = {15'd0, s_axis_tdata[19:3]} - {t1[30:0], 1'b0};
    assign n1_d = {16'd0, s_axis_tdata[19:4]} - t1;
    // stage 2
    logic        r2_v;
    logic [31:0] r2_a, r2_b;
    logic [19:0] r2_p;
    // stage 3: fine temp and pressure offset
    logic        r3_v;
    logic [31:0] r3_fine, r3_a;
    logic [19:0] r3_p;
    logic [31:0] n3_fine;
    assign n3_fine = r2_a + sar(r2_b, 14);
    // stage 4
    logic        r4_v;
    logic [31:0] r4_temp, r4_sq, r4_a5, r4_a2;
    logic [19:0] r4_p;
    logic [31:0] n4_q;
    assign n4_q = sar(r3_a, 2);
    // stage 5
    logic        r5_v;
    logic [31:0] r5_temp, r5_b6, r5_a5, r5_c3, r5_a2;
    logic [19:0] r5_p;
    // stage 6: accumulate and var1 multiply
    logic        r6_v;
    logic [31:0] r6_temp, r6_b, r6_m;
    logic [19:0] r6_p;
    logic [31:0] n5_a;
    assign n5_a = sar(sar(r5_c3, 3) + sar(r5_a2, 1), 18) + DivBias;
    // stage 7: numerator
    logic        r7_v;
    logic [31:0] r7_temp, r7_den, r7_x;
    logic [31:0] n7_den;
    assign n7_den = sar(r6_m, 15);
    logic [31:0] n7_x;
    assign n7_x = PBase - {12'd0, r6_p} - sar(sar(r6_b, 2) + {p4[15:0], 16'd0}, 12);
    // stage 8: scale
    logic        r8_v;
    logic [31:0] r8_temp, r8_den, r8_num;
    logic        r8_dbl;
    logic [31:0] n8_p;
    assign n8_p = 32'(r7_x * PScale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v; r8_v <= r7_v;
        end
        if (en) begin
            r1_a  <= 32'(n1_x * t2);
            r1_dd <= 32'(n1_d * n1_d);
            r1_p  <= s_axis_tdata[39:20];
            r2_a  <= sar(r1_a, 11);
            r2_b  <= 32'(sar(r1_dd, 12) * t3);
            r2_p  <= r1_p;
            r3_fine <= n3_fine;
            r3_a  <= sar(n3_fine, 1) - POffset;
            r3_p  <= r2_p;
            r4_temp <= sar(32'(r3_fine * 32'd5) + TRound, 8);
            r4_sq <= 32'(n4_q * n4_q);
            r4_a5 <= 32'(r3_a * p5);
            r4_a2 <= 32'(p2 * r3_a);
            r4_p  <= r3_p;
            r5_temp <= r4_temp;
            r5_b6 <= 32'(sar(r4_sq, 11) * p6);
            r5_a5 <= r4_a5;
            r5_c3 <= 32'(p3 * sar(r4_sq, 13));
            r5_a2 <= r4_a2;
            r5_p  <= r4_p;
            r6_temp <= r5_temp;
            r6_b  <= r5_b6 + {r5_a5[30:0], 1'b0};
            r6_m  <= 32'(n5_a * p1);
            r6_p  <= r5_p;
            r7_temp <= r6_temp;
            r7_den <= n7_den;
            r7_x  <= n7_x;
            r8_temp <= r7_temp;
            r8_den <= r7_den;
            r8_dbl <= !(n8_p < PSignBit);
            r8_num <= (n8_p < PSignBit) ? {n8_p[30:0], 1'b0} : n8_p;
        end
    end

    // divider, tag carries temperature, zero flag and doubling flag
    logic        dz;
    logic [31:0] dden;
    assign dz = (r8_den == '0);
    assign dden = dz ? 32'd1 : r8_den;
    logic        dv_v;
    logic [31:0] dv_q;
    logic [33:0] dv_tag;
    ptc_div #(.TAG_W(34)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r8_v), .i_num(r8_num), .i_den(dden),
        .i_tag({r8_temp, dz, r8_dbl}),
        .o_vld(dv_v), .o_quo(dv_q), .o_tag(dv_tag)
    );

    // back stages: correction
    logic [31:0] n9_p;
    assign n9_p = dv_tag[0] ? {dv_q[30:0], 1'b0} : dv_q;
    logic        r9_v, r9_z;
    logic [31:0] r9_temp, r9_p, r9_s;
    logic        r10_v, r10_z;
    logic [31:0] r10_temp, r10_p, r10_c, r10_d;
    logic [31:0] n9_q;
    assign n9_q = {3'd0, n9_p[31:3]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0; r10_v <= 1'b0; m_axis_tvalid <= 1'b0;
        end else if (en) begin
            r9_v <= dv_v; r10_v <= r9_v; m_axis_tvalid <= r10_v;
        end
        if (en) begin
            r9_temp <= dv_tag[33:2];
            r9_z <= dv_tag[1];
            r9_p <= n9_p;
            r9_s <= 32'(n9_q * n9_q) >> 13;
            r10_temp <= r9_temp;
            r10_z <= r9_z;
            r10_p <= r9_p;
            r10_c <= sar(32'(p9 * r9_s), 12);
            r10_d <= sar(32'({2'd0, r9_p[31:2]} * p8), 13);
            m_axis_tdata[31:0] <= r10_temp;
            m_axis_tdata[63:32] <= r10_z ? 32'd0 : r10_p + sar(r10_c + r10_d + p7, 4);
            m_axis_tuser <= r10_z;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
        else $error("zero divisor with nonzero pressure");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
`endif
endmodule

// File: sv/ptc_div.sv
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
// depends on ptc_pkg
module ptc_div
    import ptc_pkg::*;
#(
    parameter int unsigned TAG_W = 65
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [31:0]      o_quo,
    output logic [TAG_W-1:0] o_tag
);
    logic        r_vld [33];
    logic [31:0] r_rem [33];
    logic [31:0] r_quo [33];
    logic [31:0] r_den [33];
    logic [TAG_W-1:0] r_tag [33];

    assign r_vld[0] = i_vld;
    assign r_rem[0] = '0;
    assign r_quo[0] = i_num;
    assign r_den[0] = i_den;
    assign r_tag[0] = i_tag;

    for (genvar k = 0; k < 32; k++) begin : g_stage
        logic [32:0] n_try;
        logic [32:0] n_sub;
        assign n_try = {r_rem[k], r_quo[k][31]};
        assign n_sub = n_try - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
                if (!n_sub[32]) begin
                    r_rem[k+1] <= n_sub[31:0];
                    r_quo[k+1] <= {r_quo[k][30:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_try[31:0];
                    r_quo[k+1] <= {r_quo[k][30:0], 1'b0};
                end
            end
        end
    end

    assign o_vld = r_vld[32];
    assign o_quo = r_quo[32];
    assign o_tag = r_tag[32];
endmodule

// File: tb/ptc_checker.sv
// checker for the compensation core: watches config, input and output transfers
// holds its own calibration copy, predicts each reading pair, compares results
// depends on ptc_pkg
`timescale 1ns / 100ps
module ptc_checker
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [39:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [63:0] i_m_data,
    input  logic        i_m_user,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_zero_div_seen
);
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
        logic        div_zero;
    } t_comp_result;

    logic [31:0] cal [NumRegs];
    t_comp_result expected_results[$];

    function automatic logic [31:0] asr(input logic [31:0] x, input int s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_comp_result compensate(input logic [19:0] adc_t,
                                                input logic [19:0] adc_p);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, sq, p, c, pt, pp;
        t_comp_result r;
        t1 = {16'd0, cal[RegT1][15:0]};
        t2 = sext(cal[RegT2T3][15:0]);  t3 = sext(cal[RegT2T3][31:16]);
        p1 = {16'd0, cal[RegP1][15:0]};
        p2 = sext(cal[RegP2P3][15:0]);  p3 = sext(cal[RegP2P3][31:16]);
        p4 = sext(cal[RegP4P5][15:0]);  p5 = sext(cal[RegP4P5][31:16]);
        p6 = sext(cal[RegP6P7][15:0]);  p7 = sext(cal[RegP6P7][31:16]);
        p8 = sext(cal[RegP8P9][15:0]);  p9 = sext(cal[RegP8P9][31:16]);
        pt = {12'd0, adc_t};
        pp = {12'd0, adc_p};
        a = asr(((pt >> 3) - (t1 << 1)) * t2, 11);
        d = (pt >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        fine = a + b;
        r.temp_centi = asr(fine * 32'd5 + 32'd128, 8);
        a = asr(fine, 1) - 32'd64000;
        sq = asr(a, 2) * asr(a, 2);
        b = asr(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((32'd32768 + a) * p1, 15);
        if (a == 0) begin
            r.press_pa = 0;
            r.div_zero = 1'b1;
        end else begin
            p = (32'd1048576 - pp - asr(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else                   p = (p / a) * 32'd2;
            c = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            d = asr((p >> 2) * p8, 13);
            r.press_pa = p + asr(c + d + p7, 4);
            r.div_zero = 1'b0;
        end
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_comp_result want, got;
        if (!i_rst_n) begin
            foreach (cal[i]) cal[i] <= '0;
            expected_results.delete();
            o_fail_count <= 0;
            o_zero_div_seen <= 0;
        end else begin
            // output compared against predictions made before this edge's input
            if (i_m_valid && i_m_ready) begin
                got = {i_m_data[31:0], i_m_data[63:32], i_m_user};
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("mismatch: unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.div_zero) o_zero_div_seen <= o_zero_div_seen + 1;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: temp exp %0d got %0d, press exp %0d got %0d, dz exp %0b got %0b",
                                     $signed(want.temp_centi), $signed(got.temp_centi),
                                     want.press_pa, got.press_pa, want.div_zero, got.div_zero);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                expected_results.push_back(compensate(i_s_data[19:0], i_s_data[39:20]));
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NumRegs) begin
                if (i_cfg_index == RegT1 || i_cfg_index == RegP1)
                    cal[i_cfg_index] <= {16'd0, i_cfg_data[15:0]};
                else
                    cal[i_cfg_index] <= i_cfg_data;
            end
        end
    end
endmodule

// File: tb/tb.sv
// testbench top for the compensation core: clock, reset, stimulus and verdict
// depends on ptc_pkg, ptc_checker and the core
`timescale 1ns / 100ps
module tb;
    import ptc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [39:0] in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_data;
    logic        out_user;
    int          fail_count, pending, zero_div_seen;
    int          cycle_count = 0;
    int          readings_sent = 0;
    bit          calm_tail = 0;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 60;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    pressure_temperature_compensation_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data), .m_axis_tuser(out_user)
    );

    ptc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_valid(in_valid), .i_s_ready(in_ready), .i_s_data(in_data),
        .i_m_valid(out_valid), .i_m_ready(out_ready),
        .i_m_data(out_data), .i_m_user(out_user),
        .o_fail_count(fail_count), .o_pending(pending), .o_zero_div_seen(zero_div_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 9);
            out_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        out_ready <= 1'b1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_data  <= {raw_p, raw_t};
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        readings_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // zero, max or mixed-sign calibration, plausible calibration around typical factory values, or fully random
    task automatic load_cal(input int mode);
        logic [31:0] v [7];
        case (mode)
            0: v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
            1: v = '{32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: v = '{32'h8000, 32'h8000_7FFF, 32'h8000, 32'h7FFF_8000,
                     32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF};
            3: begin
                v[0] = 27504 + $urandom_range(0, 2000);
                v[1] = {16'(-1000 + $urandom_range(0, 100)), 16'(26435 + $urandom_range(0, 500))};
                v[2] = 36477 + $urandom_range(0, 2000);
                v[3] = {16'(3024 + $urandom_range(0, 200)), 16'(-10685 + $urandom_range(0, 500))};
                v[4] = {16'(-4 + $urandom_range(0, 80)), 16'(2855 + $urandom_range(0, 300))};
                v[5] = {16'(15500 + $urandom_range(0, 100)), 16'(-7 + $urandom_range(0, 14))};
                v[6] = {16'(6000 + $urandom_range(0, 100)), 16'(-14600 + $urandom_range(0, 200))};
            end
            default: for (int i = 0; i < 7; i++) v[i] = $urandom;
        endcase
        for (int i = 0; i < 7; i++) write_reg(3'(i), v[i]);
    endtask

    function automatic logic [19:0] plausible_raw();
        return 20'(400000 + $urandom_range(0, 250000));
    endfunction

    initial begin
        logic [19:0] edge_vals [4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
        logic [19:0] rt, rp;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration gives a zero divisor
        send_reading(20'h12345, 20'hABCDE);
        drain();
        write_reg(3'd7, 32'hDEAD_BEEF);   // unknown index is dropped

        // directed: field extremes under typical, max and mixed-sign calibration
        for (int m = 1; m <= 3; m++) begin
            load_cal(m);
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j += 1 + (m != 3))
                    send_reading(edge_vals[i], edge_vals[j]);
            drain();
        end

        // random phases, mostly plausible calibration and readings
        for (int phase = 0; phase < 10; phase++) begin
            load_cal(phase % 3 == 2 ? 4 : 3);
            if (phase == 9) calm_tail = 1;
            for (int n = 0; n < 68; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    rt = 20'($urandom);
                    rp = 20'($urandom);
                end else begin
                    rt = plausible_raw();
                    rp = plausible_raw();
                end
                send_reading(rt, rp);
                // hold off until the pipe is empty once per phase
                if (n == 30) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("sent %0d reading pairs over 14 calibration sets, %0d zero-divisor results",
                 readings_sent, zero_div_seen);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
